// ----- hdl/itsp_pkg.sv -----
// Package for the IMAP token stream parser: event, class, error and mode codes,
// byte classification helpers and the result item type. No dependencies.
package itsp_pkg;

    localparam int MAX_DEPTH   = 16;
    localparam int LENGTH_BITS = 32;
    localparam int MAX_RES     = 3;

    localparam logic [2:0] EV_BYTE  = 3'd0;
    localparam logic [2:0] EV_END   = 3'd1;
    localparam logic [2:0] EV_OPEN  = 3'd2;
    localparam logic [2:0] EV_CLOSE = 3'd3;
    localparam logic [2:0] EV_ERR   = 3'd4;
    localparam logic [2:0] EV_EOS   = 3'd5;

    localparam logic [2:0] CL_ATOM    = 3'd0;
    localparam logic [2:0] CL_NUMBER  = 3'd1;
    localparam logic [2:0] CL_NIL     = 3'd2;
    localparam logic [2:0] CL_QUOTED  = 3'd3;
    localparam logic [2:0] CL_LITERAL = 3'd4;

    localparam logic [2:0] ER_ESCAPE  = 3'd0;
    localparam logic [2:0] ER_QUOTE   = 3'd1;
    localparam logic [2:0] ER_UNCLOSE = 3'd2;
    localparam logic [2:0] ER_EXPECT  = 3'd3;
    localparam logic [2:0] ER_BRACE   = 3'd4;
    localparam logic [2:0] ER_LENGTH  = 3'd5;
    localparam logic [2:0] ER_SHORT   = 3'd6;
    localparam logic [2:0] ER_DEEP    = 3'd7;

    localparam logic [3:0] M_EXPECT = 4'd0;
    localparam logic [3:0] M_ATOM   = 4'd1;
    localparam logic [3:0] M_QUOTED = 4'd2;
    localparam logic [3:0] M_ESCAPE = 4'd3;
    localparam logic [3:0] M_LDIG   = 4'd4;
    localparam logic [3:0] M_LBRACE = 4'd5;
    localparam logic [3:0] M_LCR    = 4'd6;
    localparam logic [3:0] M_LDATA  = 4'd7;
    localparam logic [3:0] M_DROP   = 4'd8;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  token_class;
        logic [7:0]  out_byte;
        logic [63:0] number_value;
        logic [2:0]  error_code;
        logic [4:0]  nest_level;
    } res_t;

    typedef struct packed {
        logic [1:0]           cnt;
        res_t [MAX_RES-1:0]   res;
    } res_group_t;

    function automatic logic is_atom_char(input logic [7:0] b);
        logic ok;
        ok = (b > 8'h20) && (b < 8'h80);
        if (b == "(" || b == ")" || b == "{" || b == "\"" || b == "%" ||
            b == "*" || b == "\\") ok = 1'b0;
        return ok;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic res_t mk(input logic [2:0] ev, input logic [2:0] cls,
                                input logic [7:0] b, input logic [63:0] v,
                                input logic [2:0] err, input logic [4:0] lvl);
        res_t r;
        r.event_res    = ev;
        r.token_class  = cls;
        r.out_byte     = b;
        r.number_value = v;
        r.error_code   = err;
        r.nest_level   = lvl;
        return r;
    endfunction

endpackage

// ----- hdl/itsp_core.sv -----
// Tokenizer state and next-state logic: one byte in, up to three events out.
// Depends on itsp_pkg.
module itsp_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 kind,
    input  logic [7:0]           in_byte,
    output itsp_pkg::res_group_t grp
);
    import itsp_pkg::*;

    localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;
    localparam logic [LENGTH_BITS-1:0] LEN_LIM = '1;

    logic [3:0]             mode_reg, mode_next;
    logic [4:0]             depth_reg, depth_next;
    logic [63:0]            acc_reg, acc_next;
    logic [3:0]             nf_reg, nf_next;   // neg, digit, ovf, bad
    logic [2:0]             nil_reg, nil_next;
    logic [LENGTH_BITS-1:0] lc_reg, lc_next;
    logic [1:0]             lf_reg, lf_next;

    // atom feed results for current byte
    logic [2:0]  feed_nil;
    logic [3:0]  feed_nf;
    logic [63:0] feed_acc;
    logic [63:0] lim, d64, acc10;
    logic [LENGTH_BITS-1:0] dl, lc10;
    // start-value results from a (possibly) updated depth/mode
    logic [7:0]  b;

    always_comb begin
        logic first;
        first = (nil_reg == 3'd0);
        b = in_byte;
        feed_nil = 3'd7;
        if (nil_reg == 3'd0 && b == "N") feed_nil = 3'd1;
        else if (nil_reg == 3'd0 && b == "n") feed_nil = 3'd4;
        else if (nil_reg == 3'd1 && b == "I") feed_nil = 3'd2;
        else if (nil_reg == 3'd2 && b == "L") feed_nil = 3'd3;
        else if (nil_reg == 3'd4 && b == "i") feed_nil = 3'd5;
        else if (nil_reg == 3'd5 && b == "l") feed_nil = 3'd6;
        d64   = {60'd0, 4'(b - "0")};
        lim   = nf_reg[0] ? NEG_LIM : POS_LIM;
        acc10 = (acc_reg << 3) + (acc_reg << 1);
        feed_nf  = nf_reg;
        feed_acc = acc_reg;
        if (first && b == "-") begin
            feed_nf[0] = 1'b1;
        end else if (is_digit(b)) begin
            feed_nf[1] = 1'b1;
            if (!nf_reg[2]) begin
                // acc*10+d > lim  <=>  acc > (lim-d)/10
                if (acc_reg > 64'h0CCC_CCCC_CCCC_CCCC ||
                    ({1'b0, acc10} + {1'b0, d64}) > {1'b0, lim})
                    feed_nf[2] = 1'b1;
                else
                    feed_acc = acc10 + d64;
            end
        end else begin
            feed_nf[3] = 1'b1;
        end
        dl   = LENGTH_BITS'(b - "0");
        lc10 = (lc_reg << 3) + (lc_reg << 1);
    end

    // fresh atom feed from reset accumulators (value start)
    logic [2:0]  f0_nil;
    logic [3:0]  f0_nf;
    logic [63:0] f0_acc;
    always_comb begin
        f0_nil = 3'd7;
        if (b == "N") f0_nil = 3'd1;
        else if (b == "n") f0_nil = 3'd4;
        f0_nf  = 4'd0;
        f0_acc = 64'd0;
        if (b == "-") f0_nf[0] = 1'b1;
        else if (is_digit(b)) begin
            f0_nf[1] = 1'b1;
            f0_acc   = d64;
        end else f0_nf[3] = 1'b1;
    end

    always_comb begin
        res_t      r [MAX_RES];
        logic [1:0] n;
        logic       do_start;
        logic       lit_ok;
        logic       ovf;
        for (int i = 0; i < MAX_RES; i++) r[i] = '0;
        n          = 2'd0;
        do_start   = 1'b0;
        mode_next  = mode_reg;
        depth_next = depth_reg;
        acc_next   = acc_reg;
        nf_next    = nf_reg;
        nil_next   = nil_reg;
        lc_next    = lc_reg;
        lf_next    = lf_reg;
        lit_ok     = 1'b0;
        ovf        = 1'b0;

        if (kind) begin
            case (mode_reg)
                M_ATOM: begin
                    if (nil_reg == 3'd3 || nil_reg == 3'd6)
                        r[0] = mk(EV_END, CL_NIL, 8'd0, 64'd0, 3'd0, depth_reg);
                    else if (nf_reg[1] && !nf_reg[2] && !nf_reg[3])
                        r[0] = mk(EV_END, CL_NUMBER, 8'd0,
                                  nf_reg[0] ? (64'd0 - acc_reg) : acc_reg,
                                  3'd0, depth_reg);
                    else
                        r[0] = mk(EV_END, CL_ATOM, 8'd0, 64'd0, 3'd0, depth_reg);
                    n = 2'd1;
                    lit_ok = 1'b1;
                end
                M_LBRACE, M_LCR: begin
                    if (lc_reg != '0) begin
                        r[0] = mk(EV_ERR, 3'd0, 8'd0, 64'd0, ER_SHORT, depth_reg);
                        n = 2'd1;
                    end else begin
                        r[0] = mk(EV_END, CL_LITERAL, 8'd0, 64'd0, 3'd0, depth_reg);
                        n = 2'd1;
                        lit_ok = 1'b1;
                    end
                end
                M_LDATA: begin
                    r[0] = mk(EV_ERR, 3'd0, 8'd0, 64'd0, ER_SHORT, depth_reg);
                    n = 2'd1;
                end
                M_QUOTED: begin
                    r[0] = mk(EV_ERR, 3'd0, 8'd0, 64'd0, ER_QUOTE, depth_reg);
                    n = 2'd1;
                end
                M_ESCAPE: begin
                    r[0] = mk(EV_ERR, 3'd0, 8'd0, 64'd0, ER_ESCAPE, depth_reg);
                    n = 2'd1;
                end
                M_LDIG: begin
                    r[0] = mk(EV_ERR, 3'd0, 8'd0, 64'd0, ER_BRACE, depth_reg);
                    n = 2'd1;
                end
                M_EXPECT: lit_ok = 1'b1;
                default: begin
                    r[0] = mk(EV_EOS, 3'd0, 8'd0, 64'd0, 3'd0, depth_reg);
                    n = 2'd1;
                end
            endcase
            if (lit_ok) begin
                if (depth_reg != 5'd0)
                    r[n] = mk(EV_ERR, 3'd0, 8'd0, 64'd0, ER_UNCLOSE, depth_reg);
                else
                    r[n] = mk(EV_EOS, 3'd0, 8'd0, 64'd0, 3'd0, depth_reg);
                n = n + 2'd1;
            end
            mode_next  = M_EXPECT;
            depth_next = 5'd0;
            acc_next   = 64'd0;
            nf_next    = 4'd0;
            nil_next   = 3'd0;
            lc_next    = '0;
            lf_next    = 2'd0;
        end else begin
            case (mode_reg)
                M_EXPECT: do_start = 1'b1;
                M_ATOM: begin
                    if (is_atom_char(b)) begin
                        nil_next = feed_nil;
                        nf_next  = feed_nf;
                        acc_next = feed_acc;
                        r[0] = mk(EV_BYTE, 3'd0, b, 64'd0, 3'd0, depth_reg);
                        n = 2'd1;
                    end else begin
                        if (nil_reg == 3'd3 || nil_reg == 3'd6)
                            r[0] = mk(EV_END, CL_NIL, 8'd0, 64'd0, 3'd0, depth_reg);
                        else if (nf_reg[1] && !nf_reg[2] && !nf_reg[3])
                            r[0] = mk(EV_END, CL_NUMBER, 8'd0,
                                      nf_reg[0] ? (64'd0 - acc_reg) : acc_reg,
                                      3'd0, depth_reg);
                        else
                            r[0] = mk(EV_END, CL_ATOM, 8'd0, 64'd0, 3'd0, depth_reg);
                        n = 2'd1;
                        mode_next = M_EXPECT;
                        do_start  = 1'b1;
                    end
                end
                M_QUOTED: begin
                    if (b == "\\") mode_next = M_ESCAPE;
                    else if (b == "\"") begin
                        r[0] = mk(EV_END, CL_QUOTED, 8'd0, 64'd0, 3'd0, depth_reg);
                        n = 2'd1;
                        mode_next = M_EXPECT;
                    end else begin
                        r[0] = mk(EV_BYTE, 3'd0, b, 64'd0, 3'd0, depth_reg);
                        n = 2'd1;
                    end
                end
                M_ESCAPE: begin
                    mode_next = M_QUOTED;
                    r[0] = mk(EV_BYTE, 3'd0, b, 64'd0, 3'd0, depth_reg);
                    n = 2'd1;
                end
                M_LDIG: begin
                    if (is_digit(b)) begin
                        lf_next[0] = 1'b1;
                        if (!lf_reg[1]) begin
                            ovf = ({4'd0, lc_reg} > {4'd0, LEN_LIM / 10}) ||
                                  (({4'd0, lc10} + {4'd0, dl}) > {4'd0, LEN_LIM});
                            if (ovf) lf_next[1] = 1'b1;
                            else     lc_next = lc10 + dl;
                        end
                    end else if (b == "}") begin
                        if (lf_reg != 2'd1) begin
                            r[0] = mk(EV_ERR, 3'd0, 8'd0, 64'd0, ER_LENGTH, depth_reg);
                            n = 2'd1;
                            mode_next = M_DROP;
                        end else mode_next = M_LBRACE;
                    end else begin
                        r[0] = mk(EV_ERR, 3'd0, 8'd0, 64'd0, ER_BRACE, depth_reg);
                        n = 2'd1;
                        mode_next = M_DROP;
                    end
                end
                M_LBRACE, M_LCR, M_LDATA: begin
                    if (mode_reg == M_LBRACE && b == 8'h0D) begin
                        mode_next = M_LCR;
                    end else if (mode_reg != M_LDATA && b == 8'h0A) begin
                        if (lc_reg == '0) begin
                            r[0] = mk(EV_END, CL_LITERAL, 8'd0, 64'd0, 3'd0, depth_reg);
                            n = 2'd1;
                            mode_next = M_EXPECT;
                        end else mode_next = M_LDATA;
                    end else if (lc_reg == '0) begin
                        r[0] = mk(EV_END, CL_LITERAL, 8'd0, 64'd0, 3'd0, depth_reg);
                        n = 2'd1;
                        mode_next = M_EXPECT;
                        do_start  = 1'b1;
                    end else begin
                        r[0] = mk(EV_BYTE, 3'd0, b, 64'd0, 3'd0, depth_reg);
                        n = 2'd1;
                        lc_next = lc_reg - 1'b1;
                        mode_next = M_LDATA;
                        if (lc_reg == LENGTH_BITS'(1)) begin
                            r[1] = mk(EV_END, CL_LITERAL, 8'd0, 64'd0, 3'd0, depth_reg);
                            n = 2'd2;
                            mode_next = M_EXPECT;
                        end
                    end
                end
                default: ;
            endcase

            if (do_start) begin
                if (b == " " || b == 8'h09) begin
                    // whitespace skipped
                end else if (b == "*" || b == "+") begin
                    r[n] = mk(EV_BYTE, 3'd0, b, 64'd0, 3'd0, depth_reg);
                    r[n+2'd1] = mk(EV_END, CL_ATOM, 8'd0, 64'd0, 3'd0, depth_reg);
                    n = n + 2'd2;
                end else if (b == "\"") begin
                    mode_next = M_QUOTED;
                end else if (b == "(") begin
                    if (depth_reg >= 5'(MAX_DEPTH)) begin
                        r[n] = mk(EV_ERR, 3'd0, 8'd0, 64'd0, ER_DEEP, depth_reg);
                        n = n + 2'd1;
                        mode_next = M_DROP;
                    end else begin
                        depth_next = depth_reg + 5'd1;
                        r[n] = mk(EV_OPEN, 3'd0, 8'd0, 64'd0, 3'd0, depth_next);
                        n = n + 2'd1;
                    end
                end else if (b == ")" && depth_reg != 5'd0) begin
                    r[n] = mk(EV_CLOSE, 3'd0, 8'd0, 64'd0, 3'd0, depth_reg);
                    n = n + 2'd1;
                    depth_next = depth_reg - 5'd1;
                end else if (b == "{") begin
                    mode_next = M_LDIG;
                    lc_next   = '0;
                    lf_next   = 2'd0;
                end else if (is_atom_char(b)) begin
                    mode_next = M_ATOM;
                    acc_next  = f0_acc;
                    nf_next   = f0_nf;
                    nil_next  = f0_nil;
                    r[n] = mk(EV_BYTE, 3'd0, b, 64'd0, 3'd0, depth_reg);
                    n = n + 2'd1;
                end else begin
                    r[n] = mk(EV_ERR, 3'd0, 8'd0, 64'd0, ER_EXPECT, depth_reg);
                    n = n + 2'd1;
                    mode_next = M_DROP;
                end
            end
        end
        grp.cnt = n;
        for (int i = 0; i < MAX_RES; i++) grp.res[i] = r[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_EXPECT;
            depth_reg <= 5'd0;
            acc_reg   <= 64'd0;
            nf_reg    <= 4'd0;
            nil_reg   <= 3'd0;
            lc_reg    <= '0;
            lf_reg    <= 2'd0;
        end else if (step) begin
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
            acc_reg   <= acc_next;
            nf_reg    <= nf_next;
            nil_reg   <= nil_next;
            lc_reg    <= lc_next;
            lf_reg    <= lf_next;
        end
    end

endmodule

// ----- hdl/itsp_out.sv -----
// Result register: holds one group of up to three events and hands them out
// one per cycle while m_ready is high. Depends on itsp_pkg.
module itsp_out (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  itsp_pkg::res_group_t grp,
    output logic                 busy,
    output logic                 can_load,
    output logic                 m_valid,
    input  logic                 m_ready,
    output itsp_pkg::res_t       res,
    output logic                 m_last
);
    import itsp_pkg::*;

    res_t [MAX_RES-1:0] buf_reg;
    logic [1:0]         cnt_reg;
    logic [1:0]         idx_reg;
    logic               pop, final_pop;

    assign m_valid   = (cnt_reg != 2'd0);
    assign res       = buf_reg[idx_reg];
    assign m_last    = (idx_reg + 2'd1 == cnt_reg);
    assign pop       = m_valid && m_ready;
    assign final_pop = pop && m_last;
    assign busy      = m_valid;
    assign can_load  = !m_valid || final_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= grp.cnt;
            idx_reg <= 2'd0;
        end else if (final_pop) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (pop) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) buf_reg <= grp.res;
    end

endmodule

// ----- hdl/imap_token_stream_parser.sv -----
// Top level of the IMAP token stream parser.
// Instantiates itsp_core and itsp_out; depends on itsp_pkg.
//
// Usage:
//  Input channel s_*: one request per response byte (s_kind = 0) or an end of
//  input marker (s_kind = 1). Output channel m_*: token events, up to three per
//  request; m_last marks the final event caused by one input request.
//  An input byte is parsed in the cycle it is accepted; its events are held
//  in a result register and appear on m_* from the next cycle.
//  One input is taken per cycle while each yields at most one event and the
//  receiver keeps m_ready high; an input that yields more events holds the
//  result register until its last is taken, as the register hands out one
//  event a cycle. Inputs that yield no event pass through at one per cycle.
//  s_ready is high whenever the result register is empty or its last event
//  is being taken; a receiver stall holds the events and backs up s_ready.
//  Reset (aresetn low, synchronous) clears the parser to expect a value at
//  list depth zero and discards any pending events.
//  After an error all bytes are dropped until the end of input marker.
module imap_token_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [2:0]  m_token_class,
    output logic [7:0]  m_out_byte,
    output logic signed [63:0] m_number_value,
    output logic [2:0]  m_error_code,
    output logic [4:0]  m_nest_level,
    output logic        m_last
);
    import itsp_pkg::*;

    res_group_t grp;
    res_t       res;
    logic       step, busy, can_load;

    assign s_ready = can_load;
    assign step    = s_valid && s_ready;

    itsp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .kind    (s_kind),
        .in_byte (s_in_byte),
        .grp     (grp)
    );

    itsp_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .grp      (grp),
        .busy     (busy),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .res      (res),
        .m_last   (m_last)
    );

    assign m_event_res    = res.event_res;
    assign m_token_class  = res.token_class;
    assign m_out_byte     = res.out_byte;
    assign m_number_value = res.number_value;
    assign m_error_code   = res.error_code;
    assign m_nest_level   = res.nest_level;

    a_nest_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_nest_level <= 5'(MAX_DEPTH))
        else $error("nest level above limit");

    a_eos_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == EV_EOS) |-> m_last)
        else $error("end of stream not last");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == EV_ERR) |-> m_last)
        else $error("error not last");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy && !(m_ready && m_last)) |-> !s_ready)
        else $error("input taken while results pending");

endmodule
